>>> design/spq_pkg.sv
// Package for the sorted priority queue: field widths, request codes,
// default parameter values and the controller state type.
// Depends on nothing; every other file of the block but spq_store imports it.
`default_nettype none

package spq_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned PrioInW      = 8;
  localparam int unsigned CountOutW    = 5;

  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefPrioBits  = 8;

  // Value returned by a dequeue that finds the queue empty.
  localparam logic [DataW-1:0] EmptyValue = '1;

  localparam logic ReqEnqueue = 1'b0;
  localparam logic ReqDequeue = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DQ_READ,
    ST_EQ_READ,
    ST_EQ_CMP,
    ST_EQ_PUT,
    ST_RESP
  } spq_state_e;

endpackage

`default_nettype wire

>>> design/spq_req_if.sv
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for the field widths.
`default_nettype none

interface spq_req_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [DataW-1:0]   item_value;
  logic        [PrioInW-1:0] item_priority;

  modport source (output valid, req_type, item_value, item_priority, input ready);
  modport sink   (input valid, req_type, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [DataW-1:0]     head_value;
  logic                        underflow;
  logic                        overflow;
  logic        [CountOutW-1:0] entry_count;

  modport source (output valid, head_value, underflow, overflow, entry_count, input ready);
  modport sink   (input valid, head_value, underflow, overflow, entry_count, output ready);
endinterface

`default_nettype wire

>>> design/spq_store.sv
// Entry memory of the sorted priority queue: one write and one read port,
// read data registered, so a read returns its entry in the cycle after it.
// Depends on nothing outside this file.
`default_nettype none

module spq_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     wen_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     ren_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wen_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/spq_ctrl.sv
// Controller of the sorted priority queue: request decoding, the insertion
// sweep over the entry memory, the head and count registers and the
// response register. Depends on spq_pkg and the channel interfaces.
`default_nettype none

module spq_ctrl #(
  parameter int unsigned Capacity = spq_pkg::DefCapacity,
  parameter int unsigned PrioBits = spq_pkg::DefPrioBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  spq_req_if.sink                          req_i,
  spq_rsp_if.source                        rsp_o,
  output      logic                        mem_wen_o,
  output      logic [$clog2(Capacity)-1:0] mem_waddr_o,
  output      logic [spq_pkg::DataW+PrioBits-1:0] mem_wdata_o,
  output      logic                        mem_ren_o,
  output      logic [$clog2(Capacity)-1:0] mem_raddr_o,
  input  wire logic [spq_pkg::DataW+PrioBits-1:0] mem_rdata_i
);
  import spq_pkg::*;

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Capacity - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Capacity);

  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] p);
    idx_next = (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] p);
    idx_prev = (p == '0) ? LastIdx : p - 1'b1;
  endfunction

  spq_state_e state_q, state_d;

  logic [IdxW-1:0]     head_q, head_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     scan_q, scan_d;
  logic [CntW-1:0]     left_q, left_d;
  logic [DataW-1:0]    new_val_q, new_val_d;
  logic [PrioBits-1:0] new_prio_q, new_prio_d;
  logic [DataW-1:0]    res_val_q, res_val_d;
  logic                res_under_q, res_under_d;
  logic                res_over_q, res_over_d;

  logic                 out_valid_q, out_valid_d;
  logic [DataW-1:0]     out_val_q, out_val_d;
  logic                 out_under_q, out_under_d;
  logic                 out_over_q, out_over_d;
  logic [CountOutW-1:0] out_cnt_q, out_cnt_d;

  logic [31:0]         prio_ext;
  logic [PrioBits-1:0] in_prio;
  logic [IdxW:0]       tail_sum;
  logic [IdxW-1:0]     tail_idx;
  logic [PrioBits-1:0] rd_prio;
  logic [DataW-1:0]    rd_val;
  logic [31:0]         cnt_ext;

  assign prio_ext = 32'(req_i.item_priority);
  assign in_prio  = prio_ext[PrioBits-1:0];
  assign rd_prio  = mem_rdata_i[PrioBits-1:0];
  assign rd_val   = mem_rdata_i[DataW+PrioBits-1:PrioBits];
  assign cnt_ext  = 32'(count_q);

  // Physical slot of the last entry; the queue lives in a ring from head_q.
  assign tail_sum = {1'b0, head_q} + (IdxW+1)'(count_q - 1'b1);
  assign tail_idx = (tail_sum >= (IdxW+1)'(Capacity)) ?
                    IdxW'(tail_sum - (IdxW+1)'(Capacity)) : tail_sum[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    left_q      <= left_d;
    new_val_q   <= new_val_d;
    new_prio_q  <= new_prio_d;
    res_val_q   <= res_val_d;
    res_under_q <= res_under_d;
    res_over_q  <= res_over_d;
    out_val_q   <= out_val_d;
    out_under_q <= out_under_d;
    out_over_q  <= out_over_d;
    out_cnt_q   <= out_cnt_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    scan_d      = scan_q;
    left_d      = left_q;
    new_val_d   = new_val_q;
    new_prio_d  = new_prio_q;
    res_val_d   = res_val_q;
    res_under_d = res_under_q;
    res_over_d  = res_over_q;
    out_val_d   = out_val_q;
    out_under_d = out_under_q;
    out_over_d  = out_over_q;
    out_cnt_d   = out_cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    mem_wen_o   = 1'b0;
    mem_waddr_o = scan_q;
    mem_wdata_o = {new_val_q, new_prio_q};
    mem_ren_o   = 1'b0;
    mem_raddr_o = scan_q;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          new_val_d   = req_i.item_value;
          new_prio_d  = in_prio;
          res_val_d   = '0;
          res_under_d = 1'b0;
          res_over_d  = 1'b0;
          if (req_i.req_type == ReqDequeue) begin
            if (count_q == '0) begin
              res_val_d   = EmptyValue;
              res_under_d = 1'b1;
              state_d     = ST_RESP;
            end else begin
              mem_ren_o   = 1'b1;
              mem_raddr_o = head_q;
              state_d     = ST_DQ_READ;
            end
          end else if (count_q == FullCnt) begin
            res_over_d = 1'b1;
            state_d    = ST_RESP;
          end else if (count_q == '0) begin
            mem_wen_o   = 1'b1;
            mem_waddr_o = head_q;
            mem_wdata_o = {req_i.item_value, in_prio};
            count_d     = count_q + 1'b1;
            state_d     = ST_RESP;
          end else begin
            scan_d  = tail_idx;
            left_d  = count_q;
            state_d = ST_EQ_READ;
          end
        end
      end

      ST_DQ_READ: begin
        res_val_d = rd_val;
        head_d    = idx_next(head_q);
        count_d   = count_q - 1'b1;
        state_d   = ST_RESP;
      end

      ST_EQ_READ: begin
        mem_ren_o   = 1'b1;
        mem_raddr_o = scan_q;
        state_d     = ST_EQ_CMP;
      end

      ST_EQ_CMP: begin
        // Entries of equal priority stay ahead of the newcomer.
        mem_wen_o   = 1'b1;
        mem_waddr_o = idx_next(scan_q);
        if (rd_prio > new_prio_q) begin
          mem_wdata_o = mem_rdata_i;
          if (left_q == CntW'(1)) begin
            state_d = ST_EQ_PUT;
          end else begin
            left_d  = left_q - 1'b1;
            scan_d  = idx_prev(scan_q);
            state_d = ST_EQ_READ;
          end
        end else begin
          count_d = count_q + 1'b1;
          state_d = ST_RESP;
        end
      end

      ST_EQ_PUT: begin
        mem_wen_o   = 1'b1;
        mem_waddr_o = scan_q;
        count_d     = count_q + 1'b1;
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_under_d = res_under_q;
          out_over_d  = res_over_q;
          out_cnt_d   = cnt_ext[CountOutW-1:0];
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.head_value  = out_val_q;
  assign rsp_o.underflow   = out_under_q;
  assign rsp_o.overflow    = out_over_q;
  assign rsp_o.entry_count = out_cnt_q;

endmodule

`default_nettype wire

>>> design/sorted_priority_queue.sv
// Sorted priority queue: a bounded queue of value and priority pairs held in
// one memory as a ring in sorted order, lowest priority number at the head
// and equal priorities served in arrival order. Every request gives exactly
// one response with the entry count after it. A dequeue reads the head entry
// and then responds; an enqueue into an empty queue is written at once, and
// a dropped enqueue (overflow) or a dequeue of an empty queue responds at
// once. Any other enqueue sweeps from the tail, reading each held entry and
// moving it one slot on while its priority number is greater than the new
// one, then writes the new entry, with an extra write step when it ends up
// at the head. The response is presented in the cycle in which the next
// request can first be accepted. The sweep goes through the single memory
// read port, whose read data is registered. A finished response waits in
// the output register; the next request is taken once the previous one has
// been moved there. No clearing pass is needed after reset.
// Depends on spq_pkg, the channel interfaces, spq_ctrl and spq_store.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned Capacity = spq_pkg::DefCapacity,
  parameter int unsigned PrioBits = spq_pkg::DefPrioBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned EntW = DataW + PrioBits;

  logic            mem_wen;
  logic [IdxW-1:0] mem_waddr;
  logic [EntW-1:0] mem_wdata;
  logic            mem_ren;
  logic [IdxW-1:0] mem_raddr;
  logic [EntW-1:0] mem_rdata;

  spq_ctrl #(
    .Capacity (Capacity),
    .PrioBits (PrioBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_wen_o   (mem_wen),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_ren_o   (mem_ren),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  spq_store #(
    .Depth (Capacity),
    .Width (EntW)
  ) u_store (
    .clk_i   (clk_i),
    .wen_i   (mem_wen),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .ren_i   (mem_ren),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

>>> design/spq_checker.sv
// Port-level checks for the sorted priority queue, attached by a bind.
// Depends on spq_pkg for field widths and the empty-queue value.
`default_nettype none

module spq_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          req_valid_i,
  input wire logic                          req_ready_i,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [spq_pkg::DataW-1:0]     head_value_i,
  input wire logic                          underflow_i,
  input wire logic                          overflow_i,
  input wire logic [spq_pkg::CountOutW-1:0] entry_count_i
);
  import spq_pkg::*;

  // A request is worked on alone: ready drops once one is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another was in progress");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(underflow_i && overflow_i))
    else $error("underflow and overflow raised together");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && underflow_i |-> head_value_i == EmptyValue && entry_count_i == '0)
    else $error("underflow response without empty value or zero count");

  a_overflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && overflow_i |-> head_value_i == '0)
    else $error("overflow response carries a value");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(head_value_i)
      && $stable(entry_count_i))
    else $error("stalled response changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .head_value_i  (rsp_o.head_value),
  .underflow_i   (rsp_o.underflow),
  .overflow_i    (rsp_o.overflow),
  .entry_count_i (rsp_o.entry_count)
);

`default_nettype wire
